>>> rtl/hbc_pkg.sv
// Shared types, field widths and command and status codes of the buffer cache tag engine.
package hbc_pkg;

	// Field widths fixed by the transaction format.
	localparam int DEV_W    = 4;
	localparam int BLK_W    = 32;
	localparam int CNT_W    = 8;
	localparam int BKT_W    = 4;
	localparam int STAMP_W  = 32;

	// Default geometry of the cache.
	localparam int DEF_NUM_BUFFERS = 32;
	localparam int DEF_NUM_BUCKETS = 13;

	// The hash sum is reduced one byte per cycle, most significant byte first.
	localparam int HASH_BITS   = 8;
	localparam int HASH_STEPS  = BLK_W / HASH_BITS;
	localparam int HASH_CNT_W  = $clog2(HASH_STEPS);
	localparam int DEV_SHIFT   = 3;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	typedef logic [1:0] cmd_t;
	typedef logic [1:0] status_t;

	localparam cmd_t CMD_GET     = 2'd0;
	localparam cmd_t CMD_RELEASE = 2'd1;
	localparam cmd_t CMD_PIN     = 2'd2;
	localparam cmd_t CMD_UNPIN   = 2'd3;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_NO_FREE   = 2'd1;
	localparam status_t ST_UNDERFLOW = 2'd2;
	localparam status_t ST_OVERFLOW  = 2'd3;

	// One buffer descriptor as held in the descriptor memory.
	typedef struct packed {
		logic [DEV_W-1:0]   dev;
		logic [BLK_W-1:0]   blk;
		logic               valid;
		logic [CNT_W-1:0]   count;
		logic [BKT_W-1:0]   bucket;
		logic [STAMP_W-1:0] stamp;
	} hbc_entry_t;

endpackage

>>> rtl/hashed_buffer_cache_lru_core.sv
// Buffer cache tag engine: descriptor memory, hash unit and scan sequencer.
// A get reduces the hash one byte at a time, then one descriptor memory read port scans
// every buffer once. Release, pin and unpin read the named buffer and adjust its count; a
// release that drops the count to zero also rehashes the tag and moves it to its bucket's head.
// One transaction is in work at a time; the next is taken the cycle after the result is queued.
// Reset is asynchronous and active low; per-buffer written flags make unwritten entries read
// as their reset value, so no clearing pass is needed.
module hashed_buffer_cache_lru_core #(
	parameter int NUM_BUFFERS = hbc_pkg::DEF_NUM_BUFFERS,
	parameter int NUM_BUCKETS = hbc_pkg::DEF_NUM_BUCKETS,
	parameter int IDX_W       = $clog2(NUM_BUFFERS)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  hbc_pkg::cmd_t           command,
	input  logic [hbc_pkg::DEV_W-1:0] device,
	input  logic [hbc_pkg::BLK_W-1:0] block_number,
	input  logic [IDX_W-1:0]        buffer_index,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [IDX_W-1:0]        granted_buffer,
	output logic                    was_hit,
	output logic                    needs_read,
	output hbc_pkg::status_t        status
);
	import hbc_pkg::*;

	localparam int SCAN_W = $clog2(NUM_BUFFERS + 1);
	localparam logic [SCAN_W-1:0] ScanEnd = SCAN_W'(NUM_BUFFERS);
	localparam logic [IDX_W:0]    NumBuf  = (IDX_W + 1)'(NUM_BUFFERS);
	localparam logic [BKT_W:0]    NbExt   = (BKT_W + 1)'(NUM_BUCKETS);
	localparam logic [BKT_W:0]    NbM1    = (BKT_W + 1)'(NUM_BUCKETS - 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_HASH   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_RDENT  = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	logic [2:0] state_q;

	// Latched transaction.
	cmd_t             cmd_q;
	logic [DEV_W-1:0] dev_q;
	logic [BLK_W-1:0] blk_q;
	logic             rel_q;

	// Hash unit.
	logic [BLK_W-1:0]      sum_q;
	logic [BKT_W-1:0]      hash_rem_q;
	logic [HASH_CNT_W-1:0] hash_cnt_q;
	logic [BKT_W-1:0]      hash_next;

	// Descriptor memory and its written flags.
	hbc_entry_t             mem [NUM_BUFFERS];
	logic [NUM_BUFFERS-1:0] written_q;
	logic                   rd_en;
	logic [IDX_W-1:0]       rd_addr;
	hbc_entry_t             rd_data_q;
	logic                   rd_flag_q;
	logic [IDX_W-1:0]       rd_idx_q;
	hbc_entry_t             rd_entry;

	// Scan pipeline.
	logic [SCAN_W-1:0]  scan_cnt_q;
	logic               scan_issue;
	logic               scan_v_s1;
	logic               v_s2;
	logic               match_s2;
	logic               free_s2;
	logic [BKT_W-1:0]   dist_s2;
	logic [STAMP_W-1:0] age_s2;
	logic [IDX_W-1:0]   idx_s2;
	hbc_entry_t         entry_s2;
	logic [BKT_W:0]     dist_raw;
	logic [BKT_W-1:0]   dist_s1;
	logic               scan_done;

	// Best candidates found so far.
	logic               hit_found_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [STAMP_W-1:0] hit_age_q;
	hbc_entry_t         hit_entry_q;
	logic               vic_found_q;
	logic [IDX_W-1:0]   vic_idx_q;
	logic [STAMP_W-1:0] vic_age_q;
	logic [BKT_W-1:0]   vic_dist_q;

	// Pending result and write-back.
	logic [IDX_W-1:0]   res_granted_q;
	logic               res_hit_q;
	logic               res_nread_q;
	status_t            res_status_q;
	logic               wr_en_q;
	logic [IDX_W-1:0]   wr_addr_q;
	hbc_entry_t         wr_entry_q;
	logic               bump_q;
	logic [STAMP_W-1:0] stamp_counter_q;

	// Output register.
	logic               out_valid_q;
	logic               finish_fire;
	logic               in_accept;

	assign in_stall    = (state_q != S_IDLE);
	assign in_accept   = in_valid && !in_stall;
	assign finish_fire = (state_q == S_FINISH) && (!out_valid_q || !out_stall);
	assign out_valid   = out_valid_q;

	// One hash step: fold one byte of the sum into the running remainder.
	always_comb begin
		logic [BKT_W:0] r5;
		r5 = '0;
		hash_next = hash_rem_q;
		for (int j = 0; j < HASH_BITS; j++) begin
			r5 = {hash_next, sum_q[BLK_W-1-j]};
			if (r5 >= NbExt) begin
				r5 = r5 - NbExt;
			end
			hash_next = r5[BKT_W-1:0];
		end
	end

	// Read port address: the named buffer at acceptance, else the scan pointer.
	assign scan_issue = (state_q == S_SCAN) && (scan_cnt_q < ScanEnd);
	always_comb begin
		rd_en   = scan_issue;
		rd_addr = scan_cnt_q[IDX_W-1:0];
		if (state_q == S_IDLE) begin
			rd_en   = in_accept && (command != CMD_GET) && ({1'b0, buffer_index} < NumBuf);
			rd_addr = buffer_index;
		end
	end

	// Synchronous read with registered data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
			rd_flag_q <= written_q[rd_addr];
			rd_idx_q  <= rd_addr;
		end
	end

	// Memory write at the end of a transaction.
	always_ff @(posedge clk) begin
		if (finish_fire && wr_en_q) begin
			mem[wr_addr_q] <= wr_entry_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (finish_fire && wr_en_q) begin
			written_q[wr_addr_q] <= 1'b1;
		end
	end

	// A never-written entry reads as its reset value.
	always_comb begin
		rd_entry = rd_data_q;
		if (!rd_flag_q) begin
			rd_entry        = '0;
			rd_entry.stamp  = STAMP_W'(rd_idx_q);
		end
	end

	// Bucket distance from the tag's bucket, starting at the bucket after it.
	always_comb begin
		dist_raw = {1'b0, rd_entry.bucket} + (NbM1 - {1'b0, hash_rem_q});
		if (dist_raw >= NbExt) begin
			dist_raw = dist_raw - NbExt;
		end
		dist_s1 = dist_raw[BKT_W-1:0];
	end

	// Second scan stage: tag match, free flag and age of each descriptor.
	always_ff @(posedge clk) begin
		if (scan_v_s1) begin
			match_s2 <= (rd_entry.bucket == hash_rem_q) && (rd_entry.dev == dev_q) &&
				(rd_entry.blk == blk_q);
			free_s2  <= (rd_entry.count == '0);
			dist_s2  <= dist_s1;
			age_s2   <= stamp_counter_q - rd_entry.stamp;
			idx_s2   <= rd_idx_q;
			entry_s2 <= rd_entry;
		end
	end

	assign scan_done = (state_q == S_SCAN) && (scan_cnt_q == ScanEnd) && !scan_v_s1 && !v_s2;

	// Candidate tracking: youngest hit, and oldest free buffer in the nearest bucket.
	always_ff @(posedge clk) begin
		if (v_s2 && match_s2 && (!hit_found_q || (age_s2 < hit_age_q))) begin
			hit_idx_q   <= idx_s2;
			hit_age_q   <= age_s2;
			hit_entry_q <= entry_s2;
		end
		if (v_s2 && free_s2 && (!vic_found_q || (dist_s2 < vic_dist_q) ||
			((dist_s2 == vic_dist_q) && (age_s2 > vic_age_q)))) begin
			vic_idx_q  <= idx_s2;
			vic_age_q  <= age_s2;
			vic_dist_q <= dist_s2;
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			scan_v_s1       <= 1'b0;
			v_s2            <= 1'b0;
			hit_found_q     <= 1'b0;
			vic_found_q     <= 1'b0;
			wr_en_q         <= 1'b0;
			bump_q          <= 1'b0;
			rel_q           <= 1'b0;
			hash_cnt_q      <= '0;
			scan_cnt_q      <= '0;
			stamp_counter_q <= STAMP_W'(NUM_BUFFERS);
			out_valid_q     <= 1'b0;
		end else begin
			scan_v_s1 <= scan_issue;
			v_s2      <= scan_v_s1;
			if (v_s2 && match_s2) begin
				hit_found_q <= 1'b1;
			end
			if (v_s2 && free_s2) begin
				vic_found_q <= 1'b1;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						wr_en_q <= 1'b0;
						bump_q  <= 1'b0;
						rel_q   <= 1'b0;
						if (command == CMD_GET) begin
							hash_cnt_q <= '0;
							state_q    <= S_HASH;
						end else if ({1'b0, buffer_index} < NumBuf) begin
							state_q <= S_RDENT;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_HASH: begin
					hash_cnt_q <= hash_cnt_q + 1'b1;
					if (hash_cnt_q == HASH_CNT_W'(HASH_STEPS - 1)) begin
						if (rel_q) begin
							state_q <= S_FINISH;
						end else begin
							hit_found_q <= 1'b0;
							vic_found_q <= 1'b0;
							scan_cnt_q  <= '0;
							state_q     <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_issue) begin
						scan_cnt_q <= scan_cnt_q + 1'b1;
					end
					if (scan_done) begin
						wr_en_q <= hit_found_q || vic_found_q;
						bump_q  <= !hit_found_q && vic_found_q;
						state_q <= S_FINISH;
					end
				end
				S_RDENT: begin
					if (cmd_q == CMD_PIN) begin
						wr_en_q <= (rd_entry.count != COUNT_MAX);
						state_q <= S_FINISH;
					end else if (rd_entry.count == '0) begin
						state_q <= S_FINISH;
					end else if ((cmd_q == CMD_RELEASE) && (rd_entry.count == CNT_W'(1))) begin
						wr_en_q    <= 1'b1;
						bump_q     <= 1'b1;
						rel_q      <= 1'b1;
						hash_cnt_q <= '0;
						state_q    <= S_HASH;
					end else begin
						wr_en_q <= 1'b1;
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (finish_fire) begin
						out_valid_q <= 1'b1;
						if (bump_q) begin
							stamp_counter_q <= stamp_counter_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload of the transaction, the hash unit and the pending result.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q         <= command;
			dev_q         <= device;
			blk_q         <= block_number;
			sum_q         <= {{(BLK_W - DEV_W - DEV_SHIFT){1'b0}}, device, {DEV_SHIFT{1'b0}}} +
				block_number;
			hash_rem_q    <= '0;
			res_granted_q <= buffer_index;
			res_hit_q     <= 1'b0;
			res_nread_q   <= 1'b0;
			res_status_q  <= ST_OK;
			wr_addr_q     <= buffer_index;
		end
		if (state_q == S_HASH) begin
			hash_rem_q <= hash_next;
			sum_q      <= sum_q << HASH_BITS;
			if (rel_q && (hash_cnt_q == HASH_CNT_W'(HASH_STEPS - 1))) begin
				wr_entry_q.bucket <= hash_next;
				wr_entry_q.stamp  <= stamp_counter_q;
			end
		end
		// Release, pin and unpin: adjust the count of the named buffer.
		if (state_q == S_RDENT) begin
			wr_entry_q <= rd_entry;
			if (cmd_q == CMD_PIN) begin
				if (rd_entry.count == COUNT_MAX) begin
					res_status_q <= ST_OVERFLOW;
				end else begin
					wr_entry_q.count <= rd_entry.count + 1'b1;
				end
			end else if (rd_entry.count == '0) begin
				res_status_q <= ST_UNDERFLOW;
			end else begin
				wr_entry_q.count <= rd_entry.count - 1'b1;
				if ((cmd_q == CMD_RELEASE) && (rd_entry.count == CNT_W'(1))) begin
					sum_q      <= {{(BLK_W - DEV_W - DEV_SHIFT){1'b0}}, rd_entry.dev,
						{DEV_SHIFT{1'b0}}} + rd_entry.blk;
					hash_rem_q <= '0;
				end
			end
		end
		// Get: hit, victim retag, or no free buffer.
		if (scan_done) begin
			if (hit_found_q) begin
				res_granted_q    <= hit_idx_q;
				res_hit_q        <= 1'b1;
				res_nread_q      <= !hit_entry_q.valid;
				wr_addr_q        <= hit_idx_q;
				wr_entry_q       <= hit_entry_q;
				wr_entry_q.valid <= 1'b1;
				if (hit_entry_q.count == COUNT_MAX) begin
					res_status_q <= ST_OVERFLOW;
				end else begin
					wr_entry_q.count <= hit_entry_q.count + 1'b1;
				end
			end else if (vic_found_q) begin
				res_granted_q     <= vic_idx_q;
				res_nread_q       <= 1'b1;
				wr_addr_q         <= vic_idx_q;
				wr_entry_q.dev    <= dev_q;
				wr_entry_q.blk    <= blk_q;
				wr_entry_q.valid  <= 1'b1;
				wr_entry_q.count  <= CNT_W'(1);
				wr_entry_q.bucket <= hash_rem_q;
				wr_entry_q.stamp  <= stamp_counter_q;
			end else begin
				res_granted_q <= '0;
				res_status_q  <= ST_NO_FREE;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (finish_fire) begin
			granted_buffer <= res_granted_q;
			was_hit        <= res_hit_q;
			needs_read     <= res_nread_q;
			status         <= res_status_q;
		end
	end

endmodule

>>> rtl/hbc_checker.sv
// Port-level checks of the buffer cache tag engine, bound to the top level.
module hbc_checker #(
	parameter int IDX_W = $clog2(hbc_pkg::DEF_NUM_BUFFERS)
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [IDX_W-1:0]      granted_buffer,
	input logic                  was_hit,
	input logic                  needs_read,
	input hbc_pkg::status_t      status
);
	import hbc_pkg::*;

	// A result held under stall keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(granted_buffer) &&
		$stable(was_hit) && $stable(needs_read) && $stable(status))
		else $error("stalled result changed");

	// One transaction at a time: the engine is busy after each acceptance.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

	// A hit reports only success or a saturated count.
	a_hit_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_hit |-> (status == ST_OK) || (status == ST_OVERFLOW))
		else $error("hit with bad status");

	// A failed get grants buffer zero and reports neither hit nor read.
	a_no_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NO_FREE) |->
		(granted_buffer == '0) && !was_hit && !needs_read)
		else $error("no-free result malformed");

	// Underflow comes only from release or unpin, so it reports neither hit nor read.
	a_count_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_UNDERFLOW) |-> !was_hit && !needs_read)
		else $error("underflow on a get");

endmodule

bind hashed_buffer_cache_lru_core hbc_checker #(.IDX_W(IDX_W)) u_hbc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.granted_buffer (granted_buffer),
	.was_hit        (was_hit),
	.needs_read     (needs_read),
	.status         (status)
);

>>> bench/hbc_reply_checker.sv
`timescale 1ns / 1ps
// Checker for the buffer cache tag engine: predicts each reply and compares it.
module hbc_reply_checker #(
	parameter int NUM_BUFFERS = hbc_pkg::DEF_NUM_BUFFERS,
	parameter int NUM_BUCKETS = hbc_pkg::DEF_NUM_BUCKETS,
	parameter int IDX_W       = $clog2(NUM_BUFFERS)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  hbc_pkg::cmd_t             command,
	input  logic [hbc_pkg::DEV_W-1:0] device,
	input  logic [hbc_pkg::BLK_W-1:0] block_number,
	input  logic [IDX_W-1:0]          buffer_index,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [IDX_W-1:0]          granted_buffer,
	input  logic                      was_hit,
	input  logic                      needs_read,
	input  hbc_pkg::status_t          status,
	output int                        pending,
	output int                        fail_count
);
	import hbc_pkg::*;

	typedef struct packed {
		logic [IDX_W-1:0] grant;
		logic             hit;
		logic             fill;
		status_t          st;
	} cache_reply_t;

	// Shadow copy of the descriptor table and the recency clock.
	hbc_entry_t         desc [NUM_BUFFERS];
	logic [STAMP_W-1:0] stamp_now;
	cache_reply_t       replies_due [$];

	initial fail_count = 0;

	task automatic report_fault(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	function automatic logic [BKT_W-1:0] hash_bucket(logic [DEV_W-1:0] d, logic [BLK_W-1:0] b);
		logic [BLK_W-1:0] sum;
		sum = (BLK_W'(d) << DEV_SHIFT) + b;
		return BKT_W'(sum % BLK_W'(NUM_BUCKETS));
	endfunction

	function automatic logic [STAMP_W-1:0] age(int i);
		return stamp_now - desc[i].stamp;
	endfunction

	// Moving to the head of a bucket takes the current stamp and advances the clock.
	function automatic void promote(int i, logic [BKT_W-1:0] bkt);
		desc[i].bucket = bkt;
		desc[i].stamp = stamp_now;
		stamp_now = stamp_now + 1'b1;
	endfunction

	// Applies one request to the shadow table and returns the reply it must produce.
	function automatic cache_reply_t serve(cmd_t c, logic [DEV_W-1:0] d, logic [BLK_W-1:0] b,
			logic [IDX_W-1:0] idx);
		cache_reply_t     r;
		logic [BKT_W-1:0] h;
		int               pick;
		int               probe;
		int               i;
		int               k;
		r.grant = idx;
		r.hit = 1'b0;
		r.fill = 1'b0;
		r.st = ST_OK;
		if (c == CMD_GET) begin
			h = hash_bucket(d, b);
			pick = -1;
			// The youngest matching tag in the home bucket is the hit.
			for (i = 0; i < NUM_BUFFERS; i++) begin
				if (desc[i].bucket == h && desc[i].dev == d && desc[i].blk == b &&
				    (pick < 0 || age(i) < age(pick)))
					pick = i;
			end
			if (pick >= 0) begin
				r.hit = 1'b1;
				if (desc[pick].count == COUNT_MAX)
					r.st = ST_OVERFLOW;
				else
					desc[pick].count = desc[pick].count + 1'b1;
			end else begin
				// Victim search starts in the next bucket; the home bucket comes last.
				for (k = 1; k <= NUM_BUCKETS && pick < 0; k++) begin
					probe = (int'(h) + k) % NUM_BUCKETS;
					for (i = 0; i < NUM_BUFFERS; i++) begin
						if (desc[i].bucket == BKT_W'(probe) && desc[i].count == '0 &&
						    (pick < 0 || age(i) > age(pick)))
							pick = i;
					end
				end
				if (pick >= 0) begin
					desc[pick].dev = d;
					desc[pick].blk = b;
					desc[pick].valid = 1'b0;
					desc[pick].count = CNT_W'(1);
					promote(pick, h);
				end
			end
			if (pick >= 0) begin
				r.grant = IDX_W'(pick);
				r.fill = !desc[pick].valid;
				desc[pick].valid = 1'b1;
			end else begin
				r.grant = '0;
				r.st = ST_NO_FREE;
			end
		end else if (int'(idx) < NUM_BUFFERS) begin
			if (c == CMD_PIN) begin
				if (desc[idx].count == COUNT_MAX)
					r.st = ST_OVERFLOW;
				else
					desc[idx].count = desc[idx].count + 1'b1;
			end else if (desc[idx].count == '0) begin
				r.st = ST_UNDERFLOW;
			end else begin
				desc[idx].count = desc[idx].count - 1'b1;
				if (c == CMD_RELEASE && desc[idx].count == '0)
					promote(idx, hash_bucket(desc[idx].dev, desc[idx].blk));
			end
		end
		return r;
	endfunction

	// Replies are checked before the request of the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		cache_reply_t due;
		int           i;
		if (!arst_n) begin
			for (i = 0; i < NUM_BUFFERS; i++) begin
				desc[i] = '0;
				desc[i].stamp = STAMP_W'(i);
			end
			stamp_now = STAMP_W'(NUM_BUFFERS);
			replies_due.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					report_fault($sformatf("reply with no request waiting: buffer %0d status %0d",
						granted_buffer, status));
				end else begin
					due = replies_due.pop_front();
					if (granted_buffer !== due.grant)
						report_fault($sformatf("granted_buffer %0d, expected %0d",
							granted_buffer, due.grant));
					if (was_hit !== due.hit)
						report_fault($sformatf("was_hit %0b, expected %0b", was_hit, due.hit));
					if (needs_read !== due.fill)
						report_fault($sformatf("needs_read %0b, expected %0b",
							needs_read, due.fill));
					if (status !== due.st)
						report_fault($sformatf("status %0d, expected %0d", status, due.st));
				end
			end
			if (in_valid && !in_stall)
				replies_due.push_back(serve(command, device, block_number, buffer_index));
			pending <= replies_due.size();
		end
	end

endmodule

>>> bench/hashed_buffer_cache_lru_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the buffer cache tag engine: stimulus, flow control and verdict.
module hashed_buffer_cache_lru_core_tb;
	import hbc_pkg::*;

	localparam int NUM_BUFFERS  = DEF_NUM_BUFFERS;
	localparam int IDX_W        = $clog2(NUM_BUFFERS);
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_ITEMS = 1250;
	localparam int TAG_POOL     = 40;
	localparam int MAX_WAIT     = 12;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	cmd_t              command = CMD_GET;
	logic [DEV_W-1:0]  device = '0;
	logic [BLK_W-1:0]  block_number = '0;
	logic [IDX_W-1:0]  buffer_index = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [IDX_W-1:0]  granted_buffer;
	logic              was_hit;
	logic              needs_read;
	status_t           status;

	int                replies_pending;
	int                mismatches;
	int                cycle_count = 0;

	// Buffers the bench holds references on, learned from get replies that grant a buffer and from pins.
	logic [IDX_W-1:0]  held [$];
	logic [DEV_W-1:0]  pool_dev [TAG_POOL];
	logic [BLK_W-1:0]  pool_blk [TAG_POOL];
	bit                tx_calm = 1'b0;
	bit                rx_calm = 1'b0;
	bit                rx_took = 1'b0;
	int                rx_wait = 0;

	always #4 clk = ~clk;

	hashed_buffer_cache_lru_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.device(device),
		.block_number(block_number),
		.buffer_index(buffer_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.granted_buffer(granted_buffer),
		.was_hit(was_hit),
		.needs_read(needs_read),
		.status(status)
	);

	hbc_reply_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.device(device),
		.block_number(block_number),
		.buffer_index(buffer_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.granted_buffer(granted_buffer),
		.was_hit(was_hit),
		.needs_read(needs_read),
		.status(status),
		.pending(replies_pending),
		.fail_count(mismatches)
	);

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Note which buffers a get handed out, so later transactions can return them.
	always @(posedge clk) begin
		rx_took <= out_valid && !out_stall;
		if (out_valid && !out_stall && (was_hit || needs_read))
			held.push_back(granted_buffer);
	end

	// After each reply taken, the receiver draws a random stall, or none while in a calm spell.
	always @(negedge clk) begin
		if (rx_took) begin
			if ($urandom_range(0, 99) == 0)
				rx_calm = !rx_calm;
			rx_wait = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
		end
		if (rx_wait > 0) begin
			out_stall <= 1'b1;
			rx_wait--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Presents one request after a random gap and returns at the falling edge after acceptance.
	task automatic send_item(cmd_t c, logic [DEV_W-1:0] d, logic [BLK_W-1:0] b,
			logic [IDX_W-1:0] idx);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		command <= c;
		device <= d;
		block_number <= b;
		buffer_index <= idx;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_get(logic [DEV_W-1:0] d, logic [BLK_W-1:0] b);
		send_item(CMD_GET, d, b, IDX_W'($urandom));
	endtask

	task automatic send_on(cmd_t c, logic [IDX_W-1:0] idx);
		send_item(c, DEV_W'($urandom), $urandom, idx);
	endtask

	// Stop sending until every outstanding reply has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (replies_pending != 0)
			@(negedge clk);
	endtask

	task automatic release_held();
		logic [IDX_W-1:0] b;
		while (held.size() > 0) begin
			b = held.pop_front();
			send_on(CMD_RELEASE, b);
		end
		drain();
	endtask

	function automatic logic [IDX_W-1:0] take_held();
		int p;
		p = $urandom_range(0, held.size() - 1);
		take_held = held[p];
		held.delete(p);
	endfunction

	initial begin
		int               n;
		int               k;
		int               slot;
		int               roll;
		logic [IDX_W-1:0] buf_id;
		logic [DEV_W-1:0] sat_dev;
		logic [BLK_W-1:0] sat_blk;

		for (k = 0; k < TAG_POOL; k++) begin
			pool_dev[k] = DEV_W'($urandom);
			pool_blk[k] = (k < 10) ? $urandom_range(0, 40) : $urandom;
		end

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. After reset every buffer carries tag zero in bucket zero, so the
		// first get sees many matches and must take the youngest one.
		send_get(4'h0, 32'h0);
		send_get(4'hF, 32'hFFFF_FFFF);
		send_get(4'hF, 32'hFFFF_FFFF);
		// Device term plus block number wraps past 32 bits.
		send_get(4'hF, 32'hFFFF_FFF9);
		send_get(4'h5, 32'h0000_0001);
		send_get(4'hA, 32'h8000_0000);
		send_on(CMD_PIN, 5'd31);
		send_on(CMD_UNPIN, 5'd31);
		send_on(CMD_RELEASE, 5'd31);
		send_on(CMD_RELEASE, 5'd31);
		send_on(CMD_UNPIN, 5'd20);
		send_on(CMD_PIN, 5'd20);
		send_on(CMD_RELEASE, 5'd20);
		// Tag zero still lives in many buffers of bucket zero; the one released last is the
		// youngest.
		send_get(4'h0, 32'h0);
		send_on(CMD_PIN, 5'd0);
		send_on(CMD_UNPIN, 5'd0);
		drain();
		release_held();

		// Random part: mostly gets on a small tag pool with matching releases, plus noise.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 150 == 0)
				tx_calm = ($urandom_range(0, 3) == 0);

			// Run the cache dry with fresh tags, then hand every reference back.
			if (n == RANDOM_ITEMS / 3) begin
				drain();
				repeat (NUM_BUFFERS + 3)
					send_get(DEV_W'($urandom), $urandom);
				drain();
				release_held();
			end

			// Drive one buffer to a full count, hit it there, then unwind past zero.
			if (n == 2 * RANDOM_ITEMS / 3) begin
				sat_dev = DEV_W'($urandom);
				sat_blk = $urandom;
				drain();
				release_held();
				send_get(sat_dev, sat_blk);
				drain();
				if (held.size() > 0) begin
					buf_id = held.pop_back();
					repeat (COUNT_MAX)
						send_on(CMD_PIN, buf_id);
					send_get(sat_dev, sat_blk);
					drain();
					held.delete();
					repeat (int'(COUNT_MAX) + 1)
						send_on(CMD_UNPIN, buf_id);
					send_on(CMD_RELEASE, buf_id);
				end
			end

			roll = $urandom_range(0, 99);
			if (roll < 45) begin
				if ($urandom_range(0, 9) < 7) begin
					slot = $urandom_range(0, TAG_POOL - 1);
					if ($urandom_range(0, 19) == 0) begin
						pool_dev[slot] = DEV_W'($urandom);
						pool_blk[slot] = $urandom;
					end
					send_get(pool_dev[slot], pool_blk[slot]);
				end else begin
					send_get(DEV_W'($urandom), $urandom);
				end
			end else if (roll < 80 && held.size() > 0) begin
				send_on(CMD_RELEASE, take_held());
			end else if (roll < 88 && held.size() > 0) begin
				buf_id = held[$urandom_range(0, held.size() - 1)];
				held.push_back(buf_id);
				send_on(CMD_PIN, buf_id);
			end else if (roll < 95 && held.size() > 0) begin
				send_on(CMD_UNPIN, take_held());
			end else if (roll == 99) begin
				send_on(CMD_PIN, IDX_W'($urandom));
			end else begin
				send_on(roll[0] ? CMD_RELEASE : CMD_UNPIN, IDX_W'($urandom));
			end
		end

		drain();
		repeat (64) @(negedge clk);

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> hashed_buffer_cache_lru_core.f
rtl/hbc_pkg.sv
rtl/hashed_buffer_cache_lru_core.sv
rtl/hbc_checker.sv
bench/hbc_reply_checker.sv
bench/hashed_buffer_cache_lru_core_tb.sv
